FILE: hdl/cosm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosm_pkg
// Shared types and constants of the crawler obstacle speed mixer.
// ----------------------------------------------------------------------------
package cosm_pkg;

    // Default saturation width of the drive values.
    localparam int DATA_WIDTH_DEF = 16;

    // Dead band of 0.1 in doubled Q1.14 counts.
    localparam logic [16:0] DEAD_BAND2 = 17'd3276;
    // Obstacle level of one in Q1.15.
    localparam logic [15:0] LEVEL_ONE = 16'd32768;
    // Number of quotient bits produced by the level divider.
    localparam int DIV_STEPS = 16;

    // Configuration register indexes.
    localparam logic [7:0] REG_AVOID_ENABLE   = 8'd0;
    localparam logic [7:0] REG_FRONT_DISTANCE = 8'd1;
    localparam logic [7:0] REG_BACK_DISTANCE  = 8'd2;
    localparam logic [7:0] REG_FILTER_GAIN    = 8'd3;
    localparam logic [7:0] REG_AVOID_GAIN     = 8'd4;

    // Direction codes.
    localparam logic [3:0] DIR_STOP       = 4'd0;
    localparam logic [3:0] DIR_FWD        = 4'd1;
    localparam logic [3:0] DIR_BACK       = 4'd2;
    localparam logic [3:0] DIR_RIGHT      = 4'd3;
    localparam logic [3:0] DIR_LEFT       = 4'd4;
    localparam logic [3:0] DIR_FWD_LEFT   = 4'd5;
    localparam logic [3:0] DIR_FWD_RIGHT  = 4'd6;
    localparam logic [3:0] DIR_BACK_LEFT  = 4'd7;
    localparam logic [3:0] DIR_BACK_RIGHT = 4'd8;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_DIV,
        CMD_MUL_SML,
        CMD_WB_SML,
        CMD_MUL_SMR,
        CMD_WB_SMR,
        CMD_MUL_SQ,
        CMD_WB_SQ,
        CMD_MUL_CUBE,
        CMD_WB_CUBE,
        CMD_MUL_SCALE,
        CMD_WB_SCALE,
        CMD_MUL_CORR,
        CMD_WB_CORR,
        CMD_FINISH
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic avoid_on;
        logic forward;
    } status_t;

endpackage

FILE: hdl/crawler_obstacle_speed_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crawler_obstacle_speed_mixer
// Obstacle-aware mixer of two track speed commands into saturated drives.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. With avoidance enabled the two level
// dividers produce one quotient bit per cycle, and a single shared multiplier
// then runs the smoothing products and, when the motion is forward, the
// square, cube, scaling and steering products, each as a multiply state and
// a write-back state. With avoidance disabled an accepted item goes through
// the finish state straight to the output. The result stays on the output
// until taken, and a new item is accepted in the cycle after that.
// Configuration writes are always accepted and should be made only while
// the block is idle.
module crawler_obstacle_speed_mixer #(
    parameter int DATA_WIDTH = cosm_pkg::DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // left_command, right_command, range_left, range_right
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // left_drive, right_drive, direction_code, zero fill
    output logic [1:0]  m_tuser,  // avoid_applied, drive_saturated
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    import cosm_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [15:0] left_drive, right_drive;
    logic [3:0]  direction_code;
    logic        avoid_applied, drive_saturated;

    assign cfg_ready = 1'b1;

    cosm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cosm_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .in_data         (s_tdata),
        .left_drive      (left_drive),
        .right_drive     (right_drive),
        .direction_code  (direction_code),
        .avoid_applied   (avoid_applied),
        .drive_saturated (drive_saturated)
    );

    // Pack the result fields.
    assign m_tdata = {4'd0, direction_code, right_drive, left_drive};
    assign m_tuser = {drive_saturated, avoid_applied};

endmodule

FILE: hdl/cosm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosm_ctrl
// Sequencer: divider steps, multiplier steps and the stream handshakes.
// ----------------------------------------------------------------------------
module cosm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  cosm_pkg::status_t status,
    output cosm_pkg::cmd_t   cmd
);
    import cosm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV, ST_MUL_SML, ST_WB_SML, ST_MUL_SMR, ST_WB_SMR,
        ST_MUL_SQ, ST_WB_SQ, ST_MUL_CUBE, ST_WB_CUBE, ST_MUL_SCALE,
        ST_WB_SCALE, ST_MUL_CORR, ST_WB_CORR, ST_FINISH, ST_OUT
    } state_t;

    localparam int CW = $clog2(DIV_STEPS);

    state_t        state_reg;
    logic [CW-1:0] count_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    // Command decode from the current state.
    always_comb begin
        case (state_reg)
            ST_IDLE:      cmd = s_tvalid ? CMD_LOAD : CMD_IDLE;
            ST_DIV:       cmd = CMD_DIV;
            ST_MUL_SML:   cmd = CMD_MUL_SML;
            ST_WB_SML:    cmd = CMD_WB_SML;
            ST_MUL_SMR:   cmd = CMD_MUL_SMR;
            ST_WB_SMR:    cmd = CMD_WB_SMR;
            ST_MUL_SQ:    cmd = CMD_MUL_SQ;
            ST_WB_SQ:     cmd = CMD_WB_SQ;
            ST_MUL_CUBE:  cmd = CMD_MUL_CUBE;
            ST_WB_CUBE:   cmd = CMD_WB_CUBE;
            ST_MUL_SCALE: cmd = CMD_MUL_SCALE;
            ST_WB_SCALE:  cmd = CMD_WB_SCALE;
            ST_MUL_CORR:  cmd = CMD_MUL_CORR;
            ST_WB_CORR:   cmd = CMD_WB_CORR;
            ST_FINISH:    cmd = CMD_FINISH;
            default:      cmd = CMD_IDLE;
        endcase
    end

    // State register and divider step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    count_reg <= '0;
                    if (s_tvalid) begin
                        state_reg <= status.avoid_on ? ST_DIV : ST_FINISH;
                    end
                end
                ST_DIV: begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == CW'(DIV_STEPS - 1)) begin
                        state_reg <= ST_MUL_SML;
                    end
                end
                ST_MUL_SML:   state_reg <= ST_WB_SML;
                ST_WB_SML:    state_reg <= ST_MUL_SMR;
                ST_MUL_SMR:   state_reg <= ST_WB_SMR;
                ST_WB_SMR:    state_reg <= status.forward ? ST_MUL_SQ : ST_FINISH;
                ST_MUL_SQ:    state_reg <= ST_WB_SQ;
                ST_WB_SQ:     state_reg <= ST_MUL_CUBE;
                ST_MUL_CUBE:  state_reg <= ST_WB_CUBE;
                ST_WB_CUBE:   state_reg <= ST_MUL_SCALE;
                ST_MUL_SCALE: state_reg <= ST_WB_SCALE;
                ST_WB_SCALE:  state_reg <= ST_MUL_CORR;
                ST_MUL_CORR:  state_reg <= ST_WB_CORR;
                ST_WB_CORR:   state_reg <= ST_FINISH;
                ST_FINISH:    state_reg <= ST_OUT;
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/cosm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosm_datapath
// Registers, level dividers, shared multiplier and drive recomposition.
// ----------------------------------------------------------------------------
module cosm_datapath #(
    parameter int DATA_WIDTH = cosm_pkg::DATA_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cosm_pkg::cmd_t    cmd,
    output cosm_pkg::status_t status,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_addr,
    input  logic [15:0]       cfg_data,
    input  logic [63:0]       in_data,
    output logic [15:0]       left_drive,
    output logic [15:0]       right_drive,
    output logic [3:0]        direction_code,
    output logic              avoid_applied,
    output logic              drive_saturated
);
    import cosm_pkg::*;

    localparam int SW = 34;
    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (DATA_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
    // Drive bits that lie inside the saturation width; the rest read as zero.
    localparam logic [15:0] OUT_MASK = 16'((SW'(1) <<< DATA_WIDTH) - SW'(1));

    // Configuration registers.
    logic        avoid_en_reg;
    logic [15:0] front_reg, back_reg, fgain_reg, again_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avoid_en_reg <= 1'b1;
            front_reg    <= 16'd8192;
            back_reg     <= 16'd1638;
            fgain_reg    <= 16'd3277;
            again_reg    <= 16'd4096;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_AVOID_ENABLE:   avoid_en_reg <= cfg_data[0];
                REG_FRONT_DISTANCE: front_reg    <= cfg_data;
                REG_BACK_DISTANCE:  back_reg     <= cfg_data;
                REG_FILTER_GAIN:    fgain_reg    <= cfg_data;
                REG_AVOID_GAIN:     again_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input decode.
    logic signed [15:0] cmd_l, cmd_r;
    logic        [15:0] rng_l, rng_r;
    logic signed [16:0] t2_in, r2_in;
    logic        [16:0] t2_mag, r2_mag;
    logic               ts, rs;
    logic        [3:0]  dir_in;

    assign cmd_l = in_data[15:0];
    assign cmd_r = in_data[31:16];
    assign rng_l = in_data[47:32];
    assign rng_r = in_data[63:48];
    assign t2_in = 17'(cmd_l) + 17'(cmd_r);
    assign r2_in = 17'(cmd_l) - 17'(cmd_r);
    assign t2_mag = t2_in[16] ? 17'(-t2_in) : 17'(t2_in);
    assign r2_mag = r2_in[16] ? 17'(-r2_in) : 17'(r2_in);
    assign ts = (t2_mag <= DEAD_BAND2);
    assign rs = (r2_mag <= DEAD_BAND2);

    // Direction sorting with the dead band.
    always_comb begin
        if (ts && rs)                   dir_in = DIR_STOP;
        else if (!t2_in[16] && rs)      dir_in = DIR_FWD;
        else if (t2_in[16] && rs)       dir_in = DIR_BACK;
        else if (ts && !r2_in[16])      dir_in = DIR_RIGHT;
        else if (ts)                    dir_in = DIR_LEFT;
        else if (!t2_in[16] && r2_in[16]) dir_in = DIR_FWD_LEFT;
        else if (!t2_in[16])            dir_in = DIR_FWD_RIGHT;
        else if (r2_in[16])             dir_in = DIR_BACK_LEFT;
        else                            dir_in = DIR_BACK_RIGHT;
    end

    // Clamp a reading into the window and give the level numerator.
    function automatic logic [15:0] window_num(input logic [15:0] x, input logic [15:0] f,
                                               input logic [15:0] b);
        logic [15:0] c;
        c = (x > f) ? f : x;
        c = (c < b) ? b : c;
        return 16'(f - c);
    endfunction

    logic signed [15:0] l_reg, r_reg;
    logic        [15:0] xl_reg, xr_reg;
    logic signed [16:0] t2_reg, r2_reg;
    logic        [3:0]  dir_reg;
    logic        [15:0] reml_reg, remr_reg, shl_reg, shr_reg, ql_reg, qr_reg;
    logic        [15:0] lvl_l_reg, lvl_r_reg;
    logic        [15:0] sq_reg, cube_reg;
    logic        [16:0] t2s_reg;
    logic        [19:0] corr_reg;
    logic        [32:0] prod_reg;
    logic        [16:0] mul_a;
    logic        [15:0] mul_b;
    logic        [15:0] numl, numr, den;
    logic        [16:0] trl, trr;
    logic               degen;
    logic        [15:0] raw_l, raw_r, now_sel, prev_sel, smooth_val;
    logic               left_near;
    logic        [15:0] tb;
    logic        [32:0] rnd15;
    logic        [15:0] cube_val;

    assign numl  = window_num(rng_l, front_reg, back_reg);
    assign numr  = window_num(rng_r, front_reg, back_reg);
    assign den   = 16'(front_reg - back_reg);
    assign trl   = {reml_reg, shl_reg[15]};
    assign trr   = {remr_reg, shr_reg[15]};
    assign degen = (front_reg <= back_reg);
    assign raw_l = degen ? ((xl_reg < front_reg) ? LEVEL_ONE : 16'd0) : ql_reg;
    assign raw_r = degen ? ((xr_reg < front_reg) ? LEVEL_ONE : 16'd0) : qr_reg;

    // Falling-level filter operands for the sensor being smoothed.
    always_comb begin
        if (cmd == CMD_MUL_SMR || cmd == CMD_WB_SMR) begin
            now_sel  = raw_r;
            prev_sel = lvl_r_reg;
        end else begin
            now_sel  = raw_l;
            prev_sel = lvl_l_reg;
        end
    end
    assign smooth_val = (prev_sel <= now_sel) ? now_sel
                      : 16'(prev_sel - 16'((prod_reg + 33'd32768) >> 16));

    assign left_near = !(lvl_l_reg < lvl_r_reg);
    assign tb        = left_near ? lvl_l_reg : lvl_r_reg;
    assign rnd15     = (prod_reg + 33'd16384) >> 15;
    assign cube_val  = (rnd15 > 33'(LEVEL_ONE)) ? LEVEL_ONE : rnd15[15:0];

    // Shared multiplier operand selection.
    always_comb begin
        case (cmd)
            CMD_MUL_SML,
            CMD_MUL_SMR: begin
                mul_a = 17'(16'(prev_sel - now_sel));
                mul_b = fgain_reg;
            end
            CMD_MUL_SQ: begin
                mul_a = 17'(tb);
                mul_b = tb;
            end
            CMD_MUL_CUBE: begin
                mul_a = 17'(sq_reg);
                mul_b = tb;
            end
            CMD_MUL_SCALE: begin
                mul_a = t2_reg;
                mul_b = 16'(LEVEL_ONE - cube_reg);
            end
            CMD_MUL_CORR: begin
                mul_a = 17'(cube_reg);
                mul_b = again_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 33'(mul_a) * 33'(mul_b);
    end

    // Level state, reset to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_l_reg <= '0;
            lvl_r_reg <= '0;
        end else if (cmd == CMD_WB_SML) begin
            lvl_l_reg <= smooth_val;
        end else if (cmd == CMD_WB_SMR) begin
            lvl_r_reg <= smooth_val;
        end
    end

    // Final recomposition and saturation.
    logic signed [21:0] r2n;
    logic signed [23:0] sum_l, sum_r;
    logic signed [SW-1:0] ld_w, rd_w;
    logic               fwd_path;

    assign fwd_path = avoid_en_reg && (dir_reg == DIR_FWD || dir_reg == DIR_FWD_LEFT
                                       || dir_reg == DIR_FWD_RIGHT);
    assign r2n   = left_near ? 22'(r2_reg) - 22'(signed'({2'b00, corr_reg}))
                             : 22'(r2_reg) + 22'(signed'({2'b00, corr_reg}));
    assign sum_l = 24'(signed'({1'b0, t2s_reg})) + 24'(r2n);
    assign sum_r = 24'(signed'({1'b0, t2s_reg})) - 24'(r2n);
    assign ld_w  = fwd_path ? SW'(sum_l >>> 1) : SW'(l_reg);
    assign rd_w  = fwd_path ? SW'(sum_r >>> 1) : SW'(r_reg);

    // Datapath registers driven by the command.
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_LOAD: begin
                l_reg    <= cmd_l;
                r_reg    <= cmd_r;
                xl_reg   <= rng_l;
                xr_reg   <= rng_r;
                t2_reg   <= t2_in;
                r2_reg   <= r2_in;
                dir_reg  <= dir_in;
                reml_reg <= {1'b0, numl[15:1]};
                remr_reg <= {1'b0, numr[15:1]};
                shl_reg  <= {numl[0], 15'd0};
                shr_reg  <= {numr[0], 15'd0};
            end
            CMD_DIV: begin
                if (trl >= 17'(den)) begin
                    reml_reg <= 16'(trl - 17'(den));
                    ql_reg   <= {ql_reg[14:0], 1'b1};
                end else begin
                    reml_reg <= trl[15:0];
                    ql_reg   <= {ql_reg[14:0], 1'b0};
                end
                if (trr >= 17'(den)) begin
                    remr_reg <= 16'(trr - 17'(den));
                    qr_reg   <= {qr_reg[14:0], 1'b1};
                end else begin
                    remr_reg <= trr[15:0];
                    qr_reg   <= {qr_reg[14:0], 1'b0};
                end
                shl_reg <= {shl_reg[14:0], 1'b0};
                shr_reg <= {shr_reg[14:0], 1'b0};
            end
            CMD_WB_SQ:    sq_reg   <= rnd15[15:0];
            CMD_WB_CUBE:  cube_reg <= cube_val;
            CMD_WB_SCALE: t2s_reg  <= prod_reg[31:15];
            CMD_WB_CORR:  corr_reg <= prod_reg[31:12];
            CMD_FINISH: begin
                left_drive      <= OUT_MASK & ((ld_w > SAT_HI) ? SAT_HI[15:0]
                                 : (ld_w < SAT_LO) ? SAT_LO[15:0] : ld_w[15:0]);
                right_drive     <= OUT_MASK & ((rd_w > SAT_HI) ? SAT_HI[15:0]
                                 : (rd_w < SAT_LO) ? SAT_LO[15:0] : rd_w[15:0]);
                drive_saturated <= (ld_w > SAT_HI) || (ld_w < SAT_LO)
                                || (rd_w > SAT_HI) || (rd_w < SAT_LO);
                avoid_applied   <= fwd_path;
                direction_code  <= dir_reg;
            end
            default: ;
        endcase
    end

    assign status.avoid_on = avoid_en_reg;
    assign status.forward  = fwd_path;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the crawler obstacle speed mixer. Items are driven
// on the input stream from a queue, each result is compared with a prediction
// of the drives, direction code and flags, over several register settings.
// ----------------------------------------------------------------------------
module tb;
    import cosm_pkg::*;

    typedef struct packed {
        logic [15:0] range_right;
        logic [15:0] range_left;
        logic [15:0] right_cmd;
        logic [15:0] left_cmd;
    } cmd_item_t;

    typedef struct {
        logic [15:0] left_drive;
        logic [15:0] right_drive;
        logic [3:0]  dir;
        logic        applied;
        logic        clipped;
    } drive_res_t;

    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    crawler_obstacle_speed_mixer dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mirror of the registers and level state.
    logic        m_enable;
    int unsigned m_front, m_back, m_fgain, m_again;
    int unsigned lvl_left, lvl_right;

    cmd_item_t  pending_items[$];
    drive_res_t expected_drives[$];
    int  mismatches = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    bit  hold_off = 0;
    bit  quiet = 0;
    longint cycles = 0;

    function automatic int unsigned obstacle_level(int unsigned x);
        int unsigned c;
        if (m_front <= m_back) return (x < m_front) ? 32768 : 0;
        c = (x > m_front) ? m_front : x;
        if (c < m_back) c = m_back;
        return int'((longint'(m_front - c) << 15) / longint'(m_front - m_back));
    endfunction

    function automatic int unsigned smooth_level(int unsigned prev, int unsigned now);
        longint d;
        if (prev <= now) return now;
        d = prev - now;
        return prev - int'((d * m_fgain + 32768) >> 16);
    endfunction

    function automatic logic [3:0] motion_dir(longint t2, longint r2);
        bit ts, rs;
        ts = (t2 < 0 ? -t2 : t2) <= 3276;
        rs = (r2 < 0 ? -r2 : r2) <= 3276;
        if (ts && rs) return DIR_STOP;
        if (t2 > 0 && rs) return DIR_FWD;
        if (t2 < 0 && rs) return DIR_BACK;
        if (ts && r2 > 0) return DIR_RIGHT;
        if (ts && r2 < 0) return DIR_LEFT;
        if (t2 > 0 && r2 < 0) return DIR_FWD_LEFT;
        if (t2 > 0 && r2 > 0) return DIR_FWD_RIGHT;
        if (t2 < 0 && r2 < 0) return DIR_BACK_LEFT;
        return DIR_BACK_RIGHT;
    endfunction

    function automatic longint floor_half(longint v);
        return v >>> 1;
    endfunction

    function automatic logic [15:0] clip16(longint v, ref logic clipped);
        if (v > 32767) begin
            clipped = 1'b1;
            return 16'h7fff;
        end
        if (v < -32768) begin
            clipped = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Works out the drives for one accepted item and advances the level state.
    task automatic predict_drives(cmd_item_t it);
        longint l, r, t2, r2, ld, rd, tb_lvl, sq, cube, corr;
        int unsigned a, b;
        bit left_near;
        drive_res_t res;
        l = longint'($signed(it.left_cmd));
        r = longint'($signed(it.right_cmd));
        t2 = l + r;
        r2 = l - r;
        ld = l;
        rd = r;
        res.dir = motion_dir(t2, r2);
        res.applied = 1'b0;
        res.clipped = 1'b0;
        if (m_enable) begin
            a = smooth_level(lvl_left, obstacle_level(32'(it.range_left)));
            b = smooth_level(lvl_right, obstacle_level(32'(it.range_right)));
            lvl_left = a & 16'hffff;
            lvl_right = b & 16'hffff;
            if (res.dir == DIR_FWD || res.dir == DIR_FWD_LEFT || res.dir == DIR_FWD_RIGHT) begin
                left_near = !(a < b);
                tb_lvl = left_near ? a : b;
                sq = (tb_lvl * tb_lvl + 16384) >> 15;
                cube = (sq * tb_lvl + 16384) >> 15;
                if (cube > 32768) cube = 32768;
                t2 = (t2 * (32768 - cube)) >>> 15;
                if (t2 < 0) t2 = 0;
                corr = (cube * m_again) >> 12;
                r2 = left_near ? r2 - corr : r2 + corr;
                ld = floor_half(t2 + r2);
                rd = floor_half(t2 - r2);
                res.applied = 1'b1;
            end
        end
        res.left_drive = clip16(ld, res.clipped);
        res.right_drive = clip16(rd, res.clipped);
        expected_drives.push_back(res);
    endtask

    // Input driver.
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) predict_drives(cmd_item_t'(s_tdata));
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_items.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        drive_res_t e;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                e = expected_drives.pop_front();
                if (m_tdata[15:0] !== e.left_drive || m_tdata[31:16] !== e.right_drive ||
                    m_tdata[35:32] !== e.dir || m_tdata[39:36] !== 4'd0 ||
                    m_tuser[0] !== e.applied || m_tuser[1] !== e.clipped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp L=%h R=%h dir=%0d ap=%b sat=%b, got %h user %b",
                                 e.left_drive, e.right_drive, e.dir, e.applied, e.clipped,
                                 m_tdata, m_tuser);
                end
            end
        end
        m_tready <= aresetn && !hold_off && (quiet || $urandom_range(99) >= 6);
    end

    // Long hold-off of the receiver while items keep coming.
    always @(posedge aclk) begin
        int n;
        if (hold_req && !hold_done) begin
            hold_off <= 1'b1;
            for (n = 0; n < 300; n++) @(posedge aclk);
            hold_off <= 1'b0;
            hold_done <= 1'b1;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_AVOID_ENABLE:   m_enable = val[0];
            REG_FRONT_DISTANCE: m_front = 32'(val);
            REG_BACK_DISTANCE:  m_back = 32'(val);
            REG_FILTER_GAIN:    m_fgain = 32'(val);
            REG_AVOID_GAIN:     m_again = 32'(val);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_drives.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic cmd_item_t rand_item();
        cmd_item_t it;
        int k;
        k = $urandom_range(9);
        if (k == 0) begin
            it.left_cmd = 16'($urandom);
            it.right_cmd = 16'($urandom);
        end else begin
            it.left_cmd = 16'($signed($urandom_range(32768)) - 16384);
            it.right_cmd = (k < 4) ? 16'(it.left_cmd + $urandom_range(400) - 200)
                                   : 16'($signed($urandom_range(32768)) - 16384);
        end
        it.range_left = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(10000));
        it.range_right = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(10000));
        return it;
    endfunction

    function automatic cmd_item_t mk(int l, int r, int a, int b);
        cmd_item_t it;
        it.left_cmd = 16'(l);
        it.right_cmd = 16'(r);
        it.range_left = 16'(a);
        it.range_right = 16'(b);
        return it;
    endfunction

    task automatic run_random(int n);
        repeat (n) pending_items.push_back(rand_item());
        drain();
    endtask

    initial begin
        m_enable = 1; m_front = 8192; m_back = 1638; m_fgain = 3277; m_again = 4096;
        lvl_left = 0; lvl_right = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: all nine directions, range extremes, command extremes.
        pending_items.push_back(mk(0, 0, 0, 65535));
        pending_items.push_back(mk(16384, 16384, 1000, 9000));
        pending_items.push_back(mk(-16384, -16384, 0, 0));
        pending_items.push_back(mk(8000, -8000, 0, 0));
        pending_items.push_back(mk(-8000, 8000, 0, 0));
        pending_items.push_back(mk(4000, 16384, 3000, 2000));
        pending_items.push_back(mk(16384, 4000, 2000, 3000));
        pending_items.push_back(mk(-4000, -16384, 3000, 3000));
        pending_items.push_back(mk(-16384, -4000, 65535, 65535));
        pending_items.push_back(mk(1638, 1638, 65535, 65535));
        pending_items.push_back(mk(1639, 1638, 8192, 1638));
        pending_items.push_back(mk(16384, 16384, 1638, 1638));
        pending_items.push_back(mk(16384, 16384, 65535, 65535));
        pending_items.push_back(mk(-32768, 32767, 0, 0));
        pending_items.push_back(mk(32767, 32767, 65535, 0));
        pending_items.push_back(mk(-32768, -32768, 5000, 5000));
        drain();

        // Receiver stalls for a long stretch while the sender keeps offering.
        hold_req = 1;
        run_random(40);

        run_random(400);
        write_reg(REG_AVOID_GAIN, 16'hffff);
        write_reg(REG_FILTER_GAIN, 16'hffff);
        run_random(300);
        write_reg(REG_FILTER_GAIN, 16'h0000);
        write_reg(REG_AVOID_GAIN, 16'h0000);
        write_reg(REG_FRONT_DISTANCE, 16'hffff);
        write_reg(REG_BACK_DISTANCE, 16'h0000);
        run_random(300);
        // Degenerate window.
        write_reg(REG_FRONT_DISTANCE, 16'd3000);
        write_reg(REG_BACK_DISTANCE, 16'd5000);
        write_reg(REG_AVOID_GAIN, 16'd20000);
        write_reg(REG_FILTER_GAIN, 16'd30000);
        run_random(250);
        write_reg(REG_BACK_DISTANCE, 16'd3000);
        run_random(100);
        write_reg(REG_AVOID_ENABLE, 16'd0);
        run_random(200);
        write_reg(REG_AVOID_ENABLE, 16'd1);
        write_reg(REG_FRONT_DISTANCE, 16'd8192);
        write_reg(REG_BACK_DISTANCE, 16'd1638);
        quiet = 1;
        run_random(200);
        quiet = 0;
        run_random(250);

        if (mismatches == 0 && expected_drives.size() == 0) begin
            $display("[crawler_obstacle_speed_mixer] OK");
        end else begin
            $display("[crawler_obstacle_speed_mixer] ERROR");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("[crawler_obstacle_speed_mixer] ERROR");
            $finish;
        end
    end
endmodule

FILE: sim.f
hdl/cosm_pkg.sv
hdl/cosm_ctrl.sv
hdl/cosm_datapath.sv
hdl/crawler_obstacle_speed_mixer.sv
dv/tb.sv
